@@ src/kct_pkg.sv @@
// Shared constants, codes and types of the keyed count table.
package kct_pkg;

  // Default number of table entries.
  localparam int DEPTH_DEFAULT = 16;

  // Field widths fixed by the interface.
  localparam int MODE_W  = 2;
  localparam int KEY_W   = 32;
  localparam int COUNT_W = 32;
  localparam int SLOT_W  = 4;
  localparam int OCC_W   = 5;

  // Operation codes carried on the mode field.
  localparam logic [MODE_W-1:0] MODE_ADD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SUB  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ = 2'd2;

  // What a cell does with its stored entry at the next edge.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SET_COUNT,
    CELL_SET_ENTRY,
    CELL_SHIFT
  } cell_op_t;

  // Request data broadcast to every cell of the row.
  typedef struct packed {
    logic                      read_mode;
    logic [SLOT_W-1:0]         position;
    logic signed [KEY_W-1:0]   key;
    logic signed [COUNT_W-1:0] wr_count;
  } kct_bcast_t;

endpackage

@@ src/keyed_count_table_unit.sv @@
// Top level of the keyed count table: request sequencer, row of cells and result register.
//
// An ordered table of up to TABLE_DEPTH key and count pairs, one pair per cell.
// Input channel (in_valid/in_ready) carries mode, key, amount and position:
// add to a key (appending a new entry when the key is absent and the table
// has room), subtract from a key (removing the entry and shifting later cells
// down when the count falls to zero or below), or read the entry at a
// position. Counts saturate at the signed 32-bit limits. Each transfer gives
// exactly one result transfer on the output channel (out_valid/out_ready).
// After the input transfer, the key compare is registered in every cell, the
// selected cell is gathered and registered, and then the saturated count is
// computed and the row updated. The sequencer holds one request at a time and
// takes the next one in the cycle after the result is loaded.
// When the receiver stalls, the finished result waits in the output register
// and the next item is still taken and worked on; it then waits until the
// register is free.
// Reset empties the table at once; it takes effect on the next edge.
module keyed_count_table_unit import kct_pkg::*; #(
  parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [MODE_W-1:0]         mode,
  input  logic signed [KEY_W-1:0]   key,
  input  logic signed [COUNT_W-1:0] amount,
  input  logic [SLOT_W-1:0]         position,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      hit,
  output logic [SLOT_W-1:0]         slot,
  output logic signed [KEY_W-1:0]   out_key,
  output logic signed [COUNT_W-1:0] out_count,
  output logic                      was_removed,
  output logic                      dropped_full,
  output logic [OCC_W-1:0]          occupancy
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int TOT_W = $clog2(TABLE_DEPTH + 1);
  localparam int WIDE_W = COUNT_W + 2;
  localparam logic signed [WIDE_W-1:0] SAT_HI = 34'sd2147483647;
  localparam logic signed [WIDE_W-1:0] SAT_LO = -34'sd2147483648;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_SEL,
    S_UPD,
    S_PUSH
  } state_t;

  typedef struct packed {
    logic                      hit;
    logic [SLOT_W-1:0]         slot;
    logic signed [KEY_W-1:0]   key;
    logic signed [COUNT_W-1:0] count;
    logic                      removed;
    logic                      dropped;
    logic [OCC_W-1:0]          occ;
  } result_t;

  state_t                    state;
  logic [MODE_W-1:0]         req_mode;
  logic signed [KEY_W-1:0]   req_key;
  logic signed [COUNT_W-1:0] req_amount;
  logic [SLOT_W-1:0]         req_position;
  logic [TOT_W-1:0]          total;
  logic [TOT_W-1:0]          total_next;
  result_t                   res_c;
  result_t                   res_q;
  result_t                   out_res;

  kct_bcast_t                bcast;
  logic signed [KEY_W-1:0]   cell_key   [TABLE_DEPTH];
  logic signed [COUNT_W-1:0] cell_count [TABLE_DEPTH];
  cell_op_t                  cell_op    [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]    cell_valid;
  logic [TABLE_DEPTH-1:0]    sel_vec;

  logic                      sel_any;
  logic [IDX_W-1:0]          sel_idx;
  logic signed [KEY_W-1:0]   sel_key;
  logic signed [COUNT_W-1:0] sel_count;

  logic signed [WIDE_W-1:0]  sel_ext;
  logic signed [WIDE_W-1:0]  amt_ext;
  logic signed [WIDE_W-1:0]  new_wide;
  logic signed [COUNT_W-1:0] sat_count;
  logic                      is_full;
  logic                      pos_in;
  logic                      do_set;
  logic                      do_append;
  logic                      do_shift;
  logic                      upd;
  logic                      load_out;

  assign in_ready = (state == S_IDLE);
  assign upd      = (state == S_UPD);

  // A finished result enters the output register when it is free or draining.
  assign load_out = ((state == S_UPD) || (state == S_PUSH)) && (!out_valid || out_ready);

  // Request broadcast to the row.
  assign bcast.read_mode = (req_mode == MODE_READ);
  assign bcast.position  = req_position;
  assign bcast.key       = req_key;
  assign bcast.wr_count  = do_append ? req_amount : sat_count;

  // Row of cells; on a removal, each cell from the removed one onward takes its neighbour's entry.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic signed [KEY_W-1:0]   nb_key;
    logic signed [COUNT_W-1:0] nb_count;

    if (i + 1 < TABLE_DEPTH) begin : g_nb
      assign nb_key   = cell_key[i + 1];
      assign nb_count = cell_count[i + 1];
    end else begin : g_end
      assign nb_key   = '0;
      assign nb_count = '0;
    end

    assign cell_valid[i] = (TOT_W'(i) < total);

    kct_cell #(
      .INDEX (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .bcast      (bcast),
      .op         (cell_op[i]),
      .valid      (cell_valid[i]),
      .next_key   (nb_key),
      .next_count (nb_count),
      .key_q      (cell_key[i]),
      .count_q    (cell_count[i]),
      .sel        (sel_vec[i])
    );
  end

  kct_sel #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IDX_W)
  ) u_sel (
    .clk     (clk),
    .rst     (rst),
    .sel     (sel_vec),
    .keys    (cell_key),
    .counts  (cell_count),
    .any_q   (sel_any),
    .idx_q   (sel_idx),
    .key_q   (sel_key),
    .count_q (sel_count)
  );

  // Saturating add or subtract on the selected count.
  assign sel_ext  = WIDE_W'(sel_count);
  assign amt_ext  = WIDE_W'(req_amount);
  assign new_wide = (req_mode == MODE_SUB) ? (sel_ext - amt_ext) : (sel_ext + amt_ext);

  always_comb begin
    if (new_wide > SAT_HI) begin
      sat_count = SAT_HI[COUNT_W-1:0];
    end else if (new_wide < SAT_LO) begin
      sat_count = SAT_LO[COUNT_W-1:0];
    end else begin
      sat_count = new_wide[COUNT_W-1:0];
    end
  end

  assign is_full = (total == TOT_W'(TABLE_DEPTH));
  assign pos_in  = ({{(32 - SLOT_W){1'b0}}, req_position} < 32'(total));

  // Result and table update for the request under way.
  always_comb begin
    res_c      = '0;
    do_set     = 1'b0;
    do_append  = 1'b0;
    do_shift   = 1'b0;
    total_next = total;
    unique case (req_mode)
      MODE_ADD: begin
        res_c.key = req_key;
        if (sel_any) begin
          res_c.hit   = 1'b1;
          res_c.slot  = SLOT_W'(sel_idx);
          res_c.count = sat_count;
          do_set      = 1'b1;
        end else if (!is_full) begin
          res_c.slot  = SLOT_W'(total);
          res_c.count = req_amount;
          do_append   = 1'b1;
          total_next  = total + TOT_W'(1);
        end else begin
          res_c.dropped = 1'b1;
        end
      end
      MODE_SUB: begin
        res_c.key = req_key;
        if (sel_any) begin
          res_c.hit  = 1'b1;
          res_c.slot = SLOT_W'(sel_idx);
          if (sat_count <= 0) begin
            res_c.removed = 1'b1;
            do_shift      = 1'b1;
            total_next    = total - TOT_W'(1);
          end else begin
            res_c.count = sat_count;
            do_set      = 1'b1;
          end
        end
      end
      MODE_READ: begin
        res_c.slot = req_position;
        if (pos_in) begin
          res_c.hit   = 1'b1;
          res_c.key   = sel_key;
          res_c.count = sel_count;
        end
      end
      default: begin
      end
    endcase
    res_c.occ = OCC_W'(total_next);
  end

  // Per-cell commands, applied only in the update cycle.
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      cell_op[i] = CELL_HOLD;
      if (upd) begin
        if (do_shift && (IDX_W'(i) >= sel_idx)) begin
          cell_op[i] = CELL_SHIFT;
        end else if (do_set && (IDX_W'(i) == sel_idx)) begin
          cell_op[i] = CELL_SET_COUNT;
        end else if (do_append && (TOT_W'(i) == total)) begin
          cell_op[i] = CELL_SET_ENTRY;
        end
      end
    end
  end

  // Sequencer, occupancy and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !load_out) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_mode     <= mode;
            req_key      <= key;
            req_amount   <= amount;
            req_position <= position;
            state        <= S_MATCH;
          end
        end
        S_MATCH: begin
          state <= S_SEL;
        end
        S_SEL: begin
          state <= S_UPD;
        end
        S_UPD: begin
          total <= total_next;
          res_q <= res_c;
          if (load_out) begin
            out_valid <= 1'b1;
            out_res   <= res_c;
            state     <= S_IDLE;
          end else begin
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (load_out) begin
            out_valid <= 1'b1;
            out_res   <= res_q;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign hit          = out_res.hit;
  assign slot         = out_res.slot;
  assign out_key      = out_res.key;
  assign out_count    = out_res.count;
  assign was_removed  = out_res.removed;
  assign dropped_full = out_res.dropped;
  assign occupancy    = out_res.occ;

`ifndef SYNTH
  // Keys are unique among valid entries, and a read picks one place.
  a_sel_onehot: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEL) |-> $onehot0(sel_vec))
    else $error("more than one cell selected");

  // The fill count never passes the table size.
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    (32'(total) <= 32'(TABLE_DEPTH)))
    else $error("occupancy beyond table depth");

  // The fill count moves only in the update cycle.
  a_total_upd: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(total)) |-> ($past(state) == S_UPD))
    else $error("occupancy changed outside update");

  // A result appears only from the update or hand-over states.
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $rose(out_valid)) |->
      (($past(state) == S_UPD) || ($past(state) == S_PUSH)))
    else $error("result loaded from wrong state");

  // A removal is always a hit and never a dropped add.
  a_removed_hit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && was_removed) |-> (hit && !dropped_full))
    else $error("removal without a hit");
`endif

endmodule

@@ src/kct_cell.sv @@
// One table cell: stores a key and count, compares against the request, shifts down.
module kct_cell import kct_pkg::*; #(
  parameter int unsigned INDEX = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  kct_bcast_t                bcast,
  input  cell_op_t                  op,
  input  logic                      valid,
  input  logic signed [KEY_W-1:0]   next_key,
  input  logic signed [COUNT_W-1:0] next_count,
  output logic signed [KEY_W-1:0]   key_q,
  output logic signed [COUNT_W-1:0] count_q,
  output logic                      sel
);

  logic pos_match;

  // A read selects the cell by its place in the row.
  assign pos_match = ({{(32 - SLOT_W){1'b0}}, bcast.position} == 32'(INDEX));

  // Selection flag: position match on a read, key match on an update.
  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= 1'b0;
    end else begin
      sel <= bcast.read_mode ? pos_match : (valid && (key_q == bcast.key));
    end
  end

  // Entry storage: written in place, loaded as a new entry, or taken from the neighbour.
  always_ff @(posedge clk) begin
    unique case (op)
      CELL_HOLD: begin
      end
      CELL_SET_COUNT: begin
        count_q <= bcast.wr_count;
      end
      CELL_SET_ENTRY: begin
        key_q   <= bcast.key;
        count_q <= bcast.wr_count;
      end
      CELL_SHIFT: begin
        key_q   <= next_key;
        count_q <= next_count;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ src/kct_sel.sv @@
// Gathers the selected cell of the row into its index, key and count.
module kct_sel import kct_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [DEPTH-1:0]          sel,
  input  logic signed [KEY_W-1:0]   keys   [DEPTH],
  input  logic signed [COUNT_W-1:0] counts [DEPTH],
  output logic                      any_q,
  output logic [IDX_W-1:0]          idx_q,
  output logic signed [KEY_W-1:0]   key_q,
  output logic signed [COUNT_W-1:0] count_q
);

  logic                      any_c;
  logic [IDX_W-1:0]          idx_c;
  logic signed [KEY_W-1:0]   key_c;
  logic signed [COUNT_W-1:0] count_c;

  // At most one cell is selected, so an OR over masked cells picks it out.
  always_comb begin
    any_c   = 1'b0;
    idx_c   = '0;
    key_c   = '0;
    count_c = '0;
    for (int i = 0; i < DEPTH; i++) begin
      any_c   = any_c | sel[i];
      idx_c   = idx_c | ({IDX_W{sel[i]}} & IDX_W'(i));
      key_c   = key_c | ({KEY_W{sel[i]}} & keys[i]);
      count_c = count_c | ({COUNT_W{sel[i]}} & counts[i]);
    end
  end

  // Registered so that the arithmetic of the next cycle starts from a flop.
  always_ff @(posedge clk) begin
    if (rst) begin
      any_q <= 1'b0;
    end else begin
      any_q <= any_c;
    end
    idx_q   <= idx_c;
    key_q   <= key_c;
    count_q <= count_c;
  end

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the keyed count table, with its own table predictor.
module testbench;
  import kct_pkg::*;

  localparam int TABLE_SIZE = DEPTH_DEFAULT;
  localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
  localparam logic [KEY_W-1:0] KEY_LOWEST = 32'h8000_0000;
  localparam logic [KEY_W-1:0] KEY_HIGHEST = 32'h7FFF_FFFF;
  localparam logic [COUNT_W-1:0] AMOUNT_MIN = 32'h8000_0000;
  localparam logic [COUNT_W-1:0] AMOUNT_MAX = 32'h7FFF_FFFF;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 16;
  localparam int POOL_SIZE = 24;

  // One expected or observed result transfer.
  typedef struct {
    logic                      hit;
    logic [SLOT_W-1:0]         slot;
    logic signed [KEY_W-1:0]   key;
    logic signed [COUNT_W-1:0] count;
    logic                      removed;
    logic                      dropped;
    logic [OCC_W-1:0]          occ;
  } table_result_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [MODE_W-1:0]         mode = '0;
  logic signed [KEY_W-1:0]   key = '0;
  logic signed [COUNT_W-1:0] amount = '0;
  logic [SLOT_W-1:0]         position = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      hit;
  logic [SLOT_W-1:0]         slot;
  logic signed [KEY_W-1:0]   out_key;
  logic signed [COUNT_W-1:0] out_count;
  logic                      was_removed;
  logic                      dropped_full;
  logic [OCC_W-1:0]          occupancy;

  // Predicted table contents, in insertion order.
  logic signed [KEY_W-1:0]   tally_keys [TABLE_SIZE];
  logic signed [COUNT_W-1:0] tally_counts [TABLE_SIZE];
  int                        tally_total = 0;

  table_result_t pending_results [$];
  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  int fail_count = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_ask = 0;
  int hold_seen = 0;
  int hold_left = 0;

  keyed_count_table_unit #(.TABLE_DEPTH(TABLE_SIZE)) u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .key          (key),
    .amount       (amount),
    .position     (position),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .hit          (hit),
    .slot         (slot),
    .out_key      (out_key),
    .out_count    (out_count),
    .was_removed  (was_removed),
    .dropped_full (dropped_full),
    .occupancy    (occupancy)
  );

  always #10 clk = ~clk;

  // Clamp a wide sum to the signed 32-bit range.
  function automatic logic signed [COUNT_W-1:0] clamp_count(input longint sum);
    if (sum > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
    if (sum < -longint'(64'h8000_0000)) return 32'sh8000_0000;
    return sum[COUNT_W-1:0];
  endfunction

  // Apply one operation to the predicted table and return the result it gives.
  function automatic table_result_t apply_table_op(input logic [MODE_W-1:0] op,
                                                   input logic signed [KEY_W-1:0] k,
                                                   input logic signed [COUNT_W-1:0] amt,
                                                   input logic [SLOT_W-1:0] pos);
    table_result_t r;
    int idx;
    longint sum;
    r = '{default: '0};
    idx = -1;
    if (op == MODE_ADD || op == MODE_SUB) begin
      for (int i = 0; i < tally_total; i++)
        if (idx < 0 && tally_keys[i] == k) idx = i;
      r.key = k;
    end
    case (op)
      MODE_ADD: begin
        if (idx >= 0) begin
          sum = longint'(tally_counts[idx]) + longint'(amt);
          tally_counts[idx] = clamp_count(sum);
          r.hit = 1'b1;
          r.slot = idx[SLOT_W-1:0];
          r.count = tally_counts[idx];
        end else if (tally_total < TABLE_SIZE) begin
          tally_keys[tally_total] = k;
          tally_counts[tally_total] = amt;
          r.slot = tally_total[SLOT_W-1:0];
          r.count = amt;
          tally_total++;
        end else begin
          r.dropped = 1'b1;
        end
      end
      MODE_SUB: begin
        if (idx >= 0) begin
          sum = longint'(tally_counts[idx]) - longint'(amt);
          r.hit = 1'b1;
          r.slot = idx[SLOT_W-1:0];
          if (sum <= 0) begin
            // The entry goes and everything after it closes up by one place.
            for (int i = idx; i + 1 < tally_total; i++) begin
              tally_keys[i] = tally_keys[i + 1];
              tally_counts[i] = tally_counts[i + 1];
            end
            tally_total--;
            r.removed = 1'b1;
          end else begin
            tally_counts[idx] = clamp_count(sum);
            r.count = tally_counts[idx];
          end
        end
      end
      MODE_READ: begin
        r.slot = pos;
        if (pos < tally_total) begin
          r.hit = 1'b1;
          r.key = tally_keys[pos];
          r.count = tally_counts[pos];
        end
      end
      default: ;
    endcase
    r.occ = tally_total[OCC_W-1:0];
    return r;
  endfunction

  // Offer one item, wait for its transfer and record the result it should give.
  task automatic send_op(input logic [MODE_W-1:0] op, input logic [KEY_W-1:0] k,
                         input logic [COUNT_W-1:0] amt, input logic [SLOT_W-1:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    mode <= op;
    key <= k;
    amount <= amt;
    position <= pos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(apply_table_op(op, k, amt, pos));
    @(negedge clk);
  endtask

  // Random item: mostly keys from a small pool so that hits, removals and a
  // full table all occur often, with the odd key from the whole range.
  task automatic send_random_op();
    logic [MODE_W-1:0] op;
    logic [KEY_W-1:0] k;
    logic [COUNT_W-1:0] amt;
    int pick;
    pick = $urandom_range(99);
    op = (pick < 40) ? MODE_ADD : (pick < 72) ? MODE_SUB : (pick < 94) ? MODE_READ : MODE_NONE;
    k = ($urandom_range(9) < 8) ? key_pool[$urandom_range(POOL_SIZE - 1)] : $urandom;
    pick = $urandom_range(99);
    if (pick < 70) begin
      amt = $urandom_range(20) - 2;
    end else if (pick < 85) begin
      amt = $urandom;
    end else begin
      case ($urandom_range(3))
        0: amt = AMOUNT_MIN;
        1: amt = AMOUNT_MAX;
        2: amt = '0;
        default: amt = '1;
      endcase
    end
    send_op(op, k, amt, SLOT_W'($urandom_range(15)));
  endtask

  // Saturation at both ends, misses, reads beyond the end, the unused mode
  // and removals that shift the table.
  task automatic test_directed_cases();
    send_op(MODE_ADD, KEY_LOWEST, AMOUNT_MAX, 4'd0);
    send_op(MODE_ADD, KEY_LOWEST, 32'd1, 4'd0);
    send_op(MODE_SUB, KEY_LOWEST, AMOUNT_MIN, 4'd0);
    send_op(MODE_ADD, KEY_HIGHEST, AMOUNT_MIN, 4'd0);
    send_op(MODE_ADD, KEY_HIGHEST, '1, 4'd0);
    send_op(MODE_SUB, '0, 32'd5, 4'd0);
    send_op(MODE_READ, '1, '1, 4'd15);
    send_op(MODE_NONE, '1, '1, 4'd15);
    send_op(MODE_ADD, '0, '0, 4'd0);
    send_op(MODE_SUB, KEY_LOWEST, AMOUNT_MAX, 4'd0);
    send_op(MODE_READ, '0, '0, 4'd0);
    send_op(MODE_READ, '0, '0, 4'd1);
    send_op(MODE_SUB, KEY_HIGHEST, 32'd1, 4'd0);
  endtask

  // Fill the table, add a new key to the full table, then remove from the middle.
  task automatic test_fill_and_drop();
    for (int i = 1; i < TABLE_SIZE; i++) send_op(MODE_ADD, 100 + i, i, 4'd0);
    send_op(MODE_ADD, 32'd999, 32'd3, 4'd0);
    send_op(MODE_READ, '0, '0, 4'd15);
    send_op(MODE_SUB, 32'd105, AMOUNT_MAX, 4'd0);
    send_op(MODE_READ, '0, '0, 4'd5);
  endtask

  task automatic test_random_traffic(input int n_items);
    repeat (n_items) send_random_op();
  endtask

  // The receiver holds off for a long stretch while items keep coming, so the
  // block fills up and stops taking input.
  task automatic test_output_backpressure();
    hold_ask++;
    repeat (30) send_random_op();
  endtask

  // Receiver: random holds, or one long hold when the test asks for it.
  always @(negedge clk) begin
    if (hold_ask != hold_seen) begin
      hold_seen = hold_ask;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each result transfer with the oldest expected result.
  always @(posedge clk) begin : check_results
    table_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, hit);
          fail_count++;
        end
        if (slot !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, slot);
          fail_count++;
        end
        if (out_key !== want.key) begin
          $error("out_key: expected %0d, got %0d", want.key, out_key);
          fail_count++;
        end
        if (out_count !== want.count) begin
          $error("out_count: expected %0d, got %0d", want.count, out_count);
          fail_count++;
        end
        if (was_removed !== want.removed) begin
          $error("was_removed: expected %0d, got %0d", want.removed, was_removed);
          fail_count++;
        end
        if (dropped_full !== want.dropped) begin
          $error("dropped_full: expected %0d, got %0d", want.dropped, dropped_full);
          fail_count++;
        end
        if (occupancy !== want.occ) begin
          $error("occupancy: expected %0d, got %0d", want.occ, occupancy);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: too long without any transfer on either channel ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("keyed_count_table_unit regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Test sequence.
  initial begin
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    key_pool[0] = KEY_LOWEST;
    key_pool[1] = KEY_HIGHEST;
    key_pool[2] = '0;
    key_pool[3] = '1;
    send_idle_pct = 37;
    recv_idle_pct = 68;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_fill_and_drop();
    test_random_traffic(540);

    send_idle_pct = 68;
    recv_idle_pct = 37;
    test_random_traffic(540);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_output_backpressure();
    test_random_traffic(490);

    // Let the last results drain, then allow a little extra time for strays.
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("keyed_count_table_unit regression: pass");
    end else begin
      $display("keyed_count_table_unit regression: fail");
    end
    $finish;
  end

endmodule
